>>> src/session_frame_smb2_header_extractor_defines.svh
// Assertion macros used by the session deframer back end (sfx_back).
// Each macro expects clk and rst_n in scope of the module that uses it.
`ifndef SESSION_FRAME_SMB2_HEADER_EXTRACTOR_DEFINES_SVH
`define SESSION_FRAME_SMB2_HEADER_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SFX_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfx assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SFX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfx assertion failed");

`endif

>>> src/sfx_pkg.sv
// Shared types and constants for the session deframer and SMB2 header extractor.
// No dependencies; every module file imports this package.
`default_nettype none

package sfx_pkg;

    localparam int LENGTH_BITS = 24;
    localparam int POS_BITS    = 6;
    localparam logic [POS_BITS-1:0] POS_SAT = 6'd32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;
    localparam logic REG_EXPECT_RESPONSE = 1'b0;

    localparam int OUT_DATA_BITS = 112;

    // Body byte positions of the captured header fields.
    localparam logic [POS_BITS-1:0] POS_OFFSET_LO  = 6'd4;
    localparam logic [POS_BITS-1:0] POS_OFFSET_HI  = 6'd5;
    localparam logic [POS_BITS-1:0] POS_COMMAND_LO = 6'd12;
    localparam logic [POS_BITS-1:0] POS_COMMAND_HI = 6'd13;
    localparam logic [POS_BITS-1:0] POS_FLAGS_LO   = 6'd16;
    localparam logic [POS_BITS-1:0] POS_FLAGS_HI   = 6'd19;
    localparam logic [POS_BITS-1:0] POS_MSG_ID     = 6'd24;

    localparam logic [15:0] CMD_CREATE = 16'd5;
    localparam logic [15:0] CMD_CLOSE  = 16'd6;
    localparam logic [15:0] CMD_READ   = 16'd8;
    localparam logic [15:0] CMD_WRITE  = 16'd9;

    typedef struct packed {
        logic [7:0]          data;
        logic                first;
        logic                last;
        logic [POS_BITS-1:0] pos;
    } body_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

>>> src/session_frame_smb2_header_extractor.sv
// Session deframer with SMB2 header extraction: one payload byte per item.
// Body bytes pass through a four-entry queue and an output register.
// Throughput: one byte per cycle, unless the output stalls.
// Header bytes produce no result; the output stalls only when m_axis_tready is low.
// Reset (rst_n, asynchronous, active low) clears the parser, queue and output valid,
// and sets expect_response to 0. Depends on sfx_pkg, sfx_front, sfx_queue, sfx_back.
`default_nettype none

module session_frame_smb2_header_extractor
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [7:0]                        s_axis_tdata,  // data_byte
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [7:0] body_byte, [23:8] structure_offset, [39:24] command_code,
    // [103:40] message_id, [104] is_response, [105] dfs_operation, [106] wanted
    output logic [sfx_pkg::OUT_DATA_BITS-1:0]      m_axis_tdata,
    output logic                                   m_axis_tuser,  // first_byte
    output logic                                   m_axis_tlast,  // last_byte
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [sfx_pkg::PADDR_BITS-1:0]    paddr,
    input  wire logic [sfx_pkg::PDATA_BITS-1:0]    pwdata,
    output logic [sfx_pkg::PDATA_BITS-1:0]         prdata,
    output logic                                   pready
);
    import sfx_pkg::*;

    logic           expect_response_reg;
    logic           cfg_write;
    logic           push;
    logic           pop;
    body_item_t     push_item;
    body_item_t     pop_item;
    queue_status_t  q_status;
    logic [7:0]     body_byte;
    logic [15:0]    structure_offset;
    logic [15:0]    command_code;
    logic [63:0]    message_id;
    logic           is_response;
    logic           dfs_operation;
    logic           wanted;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_EXPECT_RESPONSE) ?
                       {{(PDATA_BITS-1){1'b0}}, expect_response_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_response_reg <= 1'b0;
        end
        else if (cfg_write && paddr[2] == REG_EXPECT_RESPONSE)
        begin
            expect_response_reg <= pwdata[0];
        end
    end

    sfx_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    sfx_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    sfx_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .expect_response  (expect_response_reg),
        .q_status         (q_status),
        .q_item           (pop_item),
        .pop              (pop),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .body_byte        (body_byte),
        .first_byte       (m_axis_tuser),
        .last_byte        (m_axis_tlast),
        .structure_offset (structure_offset),
        .command_code     (command_code),
        .message_id       (message_id),
        .is_response      (is_response),
        .dfs_operation    (dfs_operation),
        .wanted           (wanted)
    );

    assign m_axis_tdata = {5'd0, wanted, dfs_operation, is_response, message_id,
                           command_code, structure_offset, body_byte};

endmodule

`default_nettype wire

>>> src/sfx_front.sv
// Front end: parses the 4-byte session header and tags each body byte.
// Depends on sfx_pkg; feeds sfx_queue.
`default_nettype none

module sfx_front
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [7:0]          in_data,
    input  wire sfx_pkg::queue_status_t q_status,
    output logic                     push,
    output sfx_pkg::body_item_t      push_item
);
    import sfx_pkg::*;

    logic                   in_body_reg, in_body_next;
    logic [1:0]             header_count_reg, header_count_next;
    logic [LENGTH_BITS-1:0] remaining_reg, remaining_next;
    logic [POS_BITS-1:0]    position_reg, position_next;
    logic [LENGTH_BITS-1:0] shifted;
    logic                   accept;
    logic                   last;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign shifted  = {remaining_reg[LENGTH_BITS-9:0], in_data};
    assign last     = (remaining_reg <= {{(LENGTH_BITS-1){1'b0}}, 1'b1});

    assign push           = accept && in_body_reg;
    assign push_item.data  = in_data;
    assign push_item.first = (position_reg == '0);
    assign push_item.last  = last;
    assign push_item.pos   = position_reg;

    always_comb
    begin
        in_body_next      = in_body_reg;
        header_count_next = header_count_reg;
        remaining_next    = remaining_reg;
        position_next     = position_reg;
        if (accept)
        begin
            if (!in_body_reg)
            begin
                if (header_count_reg == 2'd0)
                begin
                    // The first header byte carries no length bits.
                    remaining_next    = '0;
                    header_count_next = 2'd1;
                end
                else
                begin
                    remaining_next = shifted;
                    if (header_count_reg != 2'd3)
                    begin
                        header_count_next = header_count_reg + 2'd1;
                    end
                    else
                    begin
                        header_count_next = 2'd0;
                        if (shifted != '0)
                        begin
                            in_body_next  = 1'b1;
                            position_next = '0;
                        end
                    end
                end
            end
            else
            begin
                if (position_reg != POS_SAT)
                begin
                    position_next = position_reg + 1'b1;
                end
                if (last)
                begin
                    in_body_next      = 1'b0;
                    header_count_next = 2'd0;
                    remaining_next    = '0;
                end
                else
                begin
                    remaining_next = remaining_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_body_reg      <= 1'b0;
            header_count_reg <= 2'd0;
            remaining_reg    <= '0;
            position_reg     <= '0;
        end
        else
        begin
            in_body_reg      <= in_body_next;
            header_count_reg <= header_count_next;
            remaining_reg    <= remaining_next;
            position_reg     <= position_next;
        end
    end

endmodule

`default_nettype wire

>>> src/sfx_queue.sv
// Short register queue between the front end and the back end.
// Depends on sfx_pkg.
`default_nettype none

module sfx_queue
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire sfx_pkg::body_item_t push_item,
    input  wire logic                pop,
    output sfx_pkg::body_item_t      pop_item,
    output sfx_pkg::queue_status_t   status
);
    import sfx_pkg::*;

    body_item_t           slots_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]  count_reg, count_next;

    assign status.full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_item     = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QUEUE_CW'(push) - QUEUE_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> src/sfx_back.sv
// Back end: captures SMB2 header fields and drives the output register.
// Depends on sfx_pkg and the assertion macro header.
`default_nettype none
`include "session_frame_smb2_header_extractor_defines.svh"

module sfx_back
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                expect_response,
    input  wire sfx_pkg::queue_status_t q_status,
    input  wire sfx_pkg::body_item_t q_item,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [7:0]               body_byte,
    output logic                     first_byte,
    output logic                     last_byte,
    output logic [15:0]              structure_offset,
    output logic [15:0]              command_code,
    output logic [63:0]              message_id,
    output logic                     is_response,
    output logic                     dfs_operation,
    output logic                     wanted
);
    import sfx_pkg::*;

    logic [15:0] offset_reg, offset_next;
    logic [15:0] command_reg, command_next;
    logic [1:0]  flags_reg, flags_next;
    logic [63:0] msg_id_reg, msg_id_next;
    logic        out_valid_reg, out_valid_next;
    logic        cmd_ok;
    logic        want_next;

    assign pop       = !q_status.empty && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    // Captures restart at the first byte of each body, so short bodies read zero.
    always_comb
    begin
        offset_next  = q_item.first ? 16'd0 : offset_reg;
        command_next = q_item.first ? 16'd0 : command_reg;
        flags_next   = q_item.first ? 2'd0 : flags_reg;
        msg_id_next  = q_item.first ? 64'd0 : msg_id_reg;
        case (q_item.pos)
            POS_OFFSET_LO:  offset_next[7:0]   = q_item.data;
            POS_OFFSET_HI:  offset_next[15:8]  = q_item.data;
            POS_COMMAND_LO: command_next[7:0]  = q_item.data;
            POS_COMMAND_HI: command_next[15:8] = q_item.data;
            POS_FLAGS_LO:   flags_next[0]      = q_item.data[0];
            POS_FLAGS_HI:   flags_next[1]      = q_item.data[4];
            default:
            begin
                if (q_item.pos[POS_BITS-1:3] == POS_MSG_ID[POS_BITS-1:3])
                begin
                    msg_id_next[q_item.pos[2:0]*8 +: 8] = q_item.data;
                end
            end
        endcase
        cmd_ok = (command_next == CMD_CREATE) || (command_next == CMD_CLOSE) ||
                 (command_next == CMD_READ) || (command_next == CMD_WRITE);
        want_next = (flags_next[0] == expect_response) && !flags_next[1] && cmd_ok;
        out_valid_next = pop ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            offset_reg       <= offset_next;
            command_reg      <= command_next;
            flags_reg        <= flags_next;
            msg_id_reg       <= msg_id_next;
            body_byte        <= q_item.data;
            first_byte       <= q_item.first;
            last_byte        <= q_item.last;
            structure_offset <= q_item.last ? offset_next : 16'd0;
            command_code     <= q_item.last ? command_next : 16'd0;
            message_id       <= q_item.last ? msg_id_next : 64'd0;
            is_response      <= q_item.last && flags_next[0];
            dfs_operation    <= q_item.last && flags_next[1];
            wanted           <= q_item.last && want_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    `SFX_ASSERT_IMP(a_mid_fields_zero, out_valid_reg && !last_byte,
        structure_offset == 16'd0 && command_code == 16'd0 && message_id == 64'd0 &&
        !is_response && !dfs_operation)
    `SFX_ASSERT_IMP(a_wanted_cmd, out_valid_reg && wanted,
        !dfs_operation && (command_code == CMD_CREATE || command_code == CMD_CLOSE ||
        command_code == CMD_READ || command_code == CMD_WRITE))
    `SFX_ASSERT_IMP(a_wanted_last, out_valid_reg && wanted,
        last_byte && is_response == expect_response)
    `SFX_ASSERT_NEXT(a_held_on_stall, out_valid_reg && !out_ready,
        out_valid_reg && $stable(body_byte) && $stable(last_byte))

endmodule

`default_nettype wire
